[hdl/mmc3_outer_bank_mapper_top_macros.svh]
// Assertion macros for the outer bank mapper.
// Clocked on clk, disabled while rst is high; empty when SYNTHESIS is defined.
`ifndef MMC3_OUTER_BANK_MAPPER_TOP_MACROS_SVH
`define MMC3_OUTER_BANK_MAPPER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MMC3OB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MMC3OB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MMC3OB_ASSERT_NOW(lbl, ante, cons, msg)
`define MMC3OB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/mmc3ob_pkg.sv]
// Shared types and constants of the outer bank mapper.
// No dependencies; used by every module of the block.
`default_nettype none
package mmc3ob_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic        rendering_enabled;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bank;
    logic       irq_raise;
    logic       irq_ack;
    logic       mirror_write;
    logic       mirror_horizontal;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_CPU_WRITE   = 3'd0,
    OP_OUTER_WRITE = 3'd1,
    OP_TICK        = 3'd2,
    OP_PRG_LOOKUP  = 3'd3,
    OP_CHR_LOOKUP  = 3'd4
  } opcode_t;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
  localparam logic [1:0] CFG_MIRROR_LOCK = 2'd2;

  localparam logic [7:0] PRG_COUNT_RESET = 8'd32;
  localparam logic [7:0] CHR_COUNT_RESET = 8'd64;
  localparam logic [7:0] BANK7_RESET     = 8'd1;

  // CPU register decode
  localparam logic [15:0] CPU_ADDR_MASK   = 16'hE001;
  localparam logic [15:0] REG_BANK_SEL    = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRROR      = 16'hA000;
  localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] REG_IRQ_REARM   = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

  // outer register decode, address bits 2:0
  localparam logic [2:0] OUTER_PRG_BASE = 3'd0;
  localparam logic [2:0] OUTER_CHR_BASE = 3'd1;
  localparam logic [2:0] OUTER_MODE     = 3'd7;

  localparam logic [7:0] PRG_BASE_MASK = 8'h3F;
  localparam logic [2:0] BANK_IDX_MASK = 3'h7;

  // remainder unit: 9-bit dividend, 3 quotient bits per cycle
  localparam int DIV_BITS       = 9;
  localparam int DIV_RADIX_BITS = 3;
  localparam int DIV_STEPS      = DIV_BITS / DIV_RADIX_BITS;
  localparam int STEP_CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/mmc3ob_dp.sv]
// Datapath: mapper registers, item capture, remainder unit and result register.
// Depends on mmc3ob_pkg; driven by mmc3ob_ctrl.
`default_nettype none
module mmc3ob_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  mmc3ob_pkg::dp_cmd_t    cmd,
  output mmc3ob_pkg::dp_status_t status,
  input  mmc3ob_pkg::in_item_t   in_item,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  output mmc3ob_pkg::out_item_t  out_item
);
  import mmc3ob_pkg::*;

  // configuration
  logic [7:0] prg_count;
  logic [7:0] chr_count;
  logic       mirror_lock;

  // mapper state
  logic [7:0] bsel_reg;
  logic [7:0] bank_regs [8];
  logic       mirror_bit;
  logic [7:0] irq_latch;
  logic [7:0] irq_count;
  logic       reload_pending;
  logic       irq_enable;
  logic [5:0] outer_prg_base;
  logic [7:0] outer_chr_base;
  logic [7:0] mode_reg;

  // captured item and remainder unit
  in_item_t            item;
  logic [DIV_BITS-1:0] dividend;
  logic [7:0]          divisor;
  logic [7:0]          rem;
  logic                direct;
  logic [7:0]          direct_val;

  // ---- lookup set-up from the incoming beat ----
  logic                is_chr;
  logic [1:0]          prg_slot;
  logic                prg_direct;
  logic [7:0]          prg_direct_val;
  logic [2:0]          prg_idx;
  logic [DIV_BITS-1:0] prg_dividend;
  logic [2:0]          chr_slot;
  logic [7:0]          chr_inner;
  logic [DIV_BITS-1:0] chr_dividend;

  assign is_chr = (in_item.opcode == OP_CHR_LOOKUP);
  assign status.need_div = (in_item.opcode == OP_PRG_LOOKUP) || is_chr;

  assign prg_slot = in_item.address[14:13];

  always_comb begin
    prg_direct     = 1'b0;
    prg_direct_val = prg_count - 8'd2;
    prg_idx        = 3'd6;
    case (prg_slot)
      2'd0: prg_direct = bsel_reg[6];
      2'd1: prg_idx = 3'd7;
      2'd2: prg_direct = !bsel_reg[6];
      default: begin
        prg_direct     = 1'b1;
        prg_direct_val = prg_count - 8'd1;
      end
    endcase
  end

  assign prg_dividend = DIV_BITS'(outer_prg_base) + DIV_BITS'(bank_regs[prg_idx]);

  // bank-select bit 7 swaps the 2K and 1K halves
  assign chr_slot = in_item.address[12:10] ^ {bsel_reg[7], 2'b00};

  always_comb begin
    if (!chr_slot[2]) begin
      chr_inner = {bank_regs[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
    end else begin
      chr_inner = bank_regs[{1'b0, chr_slot[1:0]} + 3'd2];
    end
  end

  assign chr_dividend = DIV_BITS'(outer_chr_base) + DIV_BITS'(chr_inner);

  // ---- remainder unit: restoring, DIV_RADIX_BITS bits a cycle ----
  logic [7:0] rem_next;

  always_comb begin
    logic [8:0] t;
    rem_next = rem;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      t = {rem_next, dividend[DIV_BITS-1-k]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[7:0];
    end
  end

  // ---- effect of the captured item ----
  logic [15:0] cpu_code;
  logic        bsel_we, breg_we, mirror_we, latch_we, pend_set, en_clr, en_set;
  logic        oprg_we, ochr_we, mode_we, tick_go;
  logic [7:0]  count_next;
  logic        mirror_next;
  out_item_t   result;

  assign cpu_code   = item.address & CPU_ADDR_MASK;
  assign count_next = (irq_count == 8'd0 || reload_pending) ? irq_latch
                                                           : irq_count - 8'd1;

  always_comb begin
    bsel_we   = 1'b0;
    breg_we   = 1'b0;
    mirror_we = 1'b0;
    latch_we  = 1'b0;
    pend_set  = 1'b0;
    en_clr    = 1'b0;
    en_set    = 1'b0;
    oprg_we   = 1'b0;
    ochr_we   = 1'b0;
    mode_we   = 1'b0;
    tick_go   = 1'b0;
    result    = '0;
    unique case (item.opcode)
      OP_CPU_WRITE: begin
        unique case (cpu_code)
          REG_BANK_SEL:  bsel_we = 1'b1;
          REG_BANK_DATA: breg_we = 1'b1;
          REG_MIRROR: begin
            mirror_we           = 1'b1;
            result.mirror_write = !mirror_lock;
          end
          REG_IRQ_LATCH: latch_we = 1'b1;
          REG_IRQ_REARM: pend_set = 1'b1;
          REG_IRQ_DISABLE: begin
            en_clr         = 1'b1;
            result.irq_ack = 1'b1;
          end
          REG_IRQ_ENABLE: en_set = 1'b1;
          default: ;
        endcase
      end
      OP_OUTER_WRITE: begin
        unique case (item.address[2:0])
          OUTER_PRG_BASE: oprg_we = 1'b1;
          OUTER_CHR_BASE: ochr_we = 1'b1;
          OUTER_MODE:     mode_we = 1'b1;
          default: ;
        endcase
      end
      OP_TICK: begin
        tick_go          = item.rendering_enabled;
        result.irq_raise = item.rendering_enabled && count_next == 8'd0 && irq_enable;
      end
      OP_PRG_LOOKUP, OP_CHR_LOOKUP: begin
        if (direct) begin
          result.bank = direct_val;
        end else if (divisor != 8'd0) begin
          result.bank = rem;
        end
      end
      default: ;
    endcase
    mirror_next              = mirror_we ? item.data[0] : mirror_bit;
    result.mirror_horizontal = mirror_next;
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count      <= PRG_COUNT_RESET;
      chr_count      <= CHR_COUNT_RESET;
      mirror_lock    <= 1'b0;
      bsel_reg       <= '0;
      for (int i = 0; i < 7; i++) begin
        bank_regs[i] <= '0;
      end
      bank_regs[7]   <= BANK7_RESET;
      mirror_bit     <= 1'b0;
      irq_latch      <= '0;
      irq_count      <= '0;
      reload_pending <= 1'b0;
      irq_enable     <= 1'b0;
      outer_prg_base <= '0;
      outer_chr_base <= '0;
      mode_reg       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRG_COUNT:   prg_count <= cfg_data;
          CFG_CHR_COUNT:   chr_count <= cfg_data;
          CFG_MIRROR_LOCK: mirror_lock <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (bsel_we)  bsel_reg <= item.data;
        if (breg_we)  bank_regs[bsel_reg[2:0] & BANK_IDX_MASK] <= item.data;
        mirror_bit <= mirror_next;
        if (latch_we) irq_latch <= item.data;
        if (en_clr)   irq_enable <= 1'b0;
        if (en_set)   irq_enable <= 1'b1;
        if (oprg_we)  outer_prg_base <= 6'(item.data & PRG_BASE_MASK);
        if (ochr_we)  outer_chr_base <= item.data;
        if (mode_we)  mode_reg <= item.data;
        if (tick_go) begin
          irq_count      <= count_next;
          reload_pending <= 1'b0;
        end else if (pend_set) begin
          reload_pending <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      rem  <= '0;
      if (is_chr) begin
        dividend   <= chr_dividend;
        divisor    <= chr_count;
        direct     <= (chr_count == 8'd0);
        direct_val <= {5'b00000, in_item.address[12:10]};
      end else begin
        dividend   <= prg_dividend;
        divisor    <= prg_count;
        direct     <= prg_direct;
        direct_val <= prg_direct_val;
      end
    end else if (cmd.step) begin
      rem      <= rem_next;
      dividend <= dividend << DIV_RADIX_BITS;
    end
    if (cmd.finish) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

[hdl/mmc3ob_ctrl.sv]
// Controller: sequences capture, remainder steps and result write-back.
// Depends on mmc3ob_pkg and the assertion macro header.
`default_nettype none
`include "mmc3_outer_bank_mapper_top_macros.svh"
module mmc3ob_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mmc3ob_pkg::dp_status_t status,
  output mmc3ob_pkg::dp_cmd_t    cmd
);
  import mmc3ob_pkg::*;

  ctrl_state_t           state, state_next;
  logic [STEP_CNT_W-1:0] step_cnt, step_cnt_next;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          step_cnt_next = '0;
          state_next    = status.need_div ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        cmd.finish = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `MMC3OB_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `MMC3OB_ASSERT_NOW(a_no_overwrite, cmd.finish, out_free, "result overwritten before taken")
  `MMC3OB_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid, "finished item not presented")
  `MMC3OB_ASSERT_NEXT(a_div_len, state == ST_DIV && step_cnt == STEP_CNT_W'(DIV_STEPS - 1),
                      state == ST_FINISH, "remainder step count wrong")

endmodule
`default_nettype wire

[hdl/mmc3_outer_bank_mapper_top.sv]
// Top level of the outer bank mapper: controller plus datapath.
// Depends on mmc3ob_pkg, mmc3ob_ctrl and mmc3ob_dp.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     in_item  (in_item_t)
//  out      output     out_valid / out_ready   out_item (out_item_t)
//  cfg      input      cfg_we                  cfg_index, cfg_data
//
// Writes and ticks: the item is captured, then the result is registered once
// the output register is free; the next beat is taken after that. Lookups: the
// remainder unit first reduces the 9-bit sum by the bank count, 3 bits a cycle,
// then the result is registered likewise. One item in flight; the next beat
// is taken once the previous result sits in the output register.
// rst is synchronous and restores the power-on mapper state and counts.
// A stalled output holds the finished item in its final state until out_ready.
`default_nettype none
module mmc3_outer_bank_mapper_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mmc3ob_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mmc3ob_pkg::out_item_t out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import mmc3ob_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mmc3ob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mmc3ob_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
